FILE: src/wbrp_pkg.sv
`default_nettype none

package wbrp_pkg;

  // Address bytes at the head of every block
  localparam int unsigned ADDR_BYTES = 4;
  // Header size: address plus the 16-bit length
  localparam logic [11:0] HDR_BYTES  = 12'(ADDR_BYTES + 2);

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned REQ_LEN_W  = 12;

  // Configuration register indexes
  localparam logic CFG_MASKED_MODE    = 1'b0;
  localparam logic CFG_REQUEST_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_LEN    = 3'd1,
    PH_DATA   = 3'd2,
    PH_DATA_M = 3'd3,
    PH_MASK   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_START   = 3'd1,
    KIND_DATA    = 3'd2,
    KIND_MASK    = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_e;

  typedef struct packed {
    logic [11:0] bytes_seen;
    phase_e      phase;
    logic [15:0] phase_count;
    logic [31:0] address;
    logic [15:0] length;
    logic        invalid;
    logic        finished;
    logic [15:0] reply_total;
  } pstate_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] block_address;
    logic [15:0] block_length;
    logic [7:0]  byte_value;
    logic [15:0] byte_offset;
    logic        request_done;
    logic        request_invalid;
    logic [15:0] reply_size;
  } result_t;

  localparam pstate_t PSTATE_CLEAR = '{
    bytes_seen:  12'd0,
    phase:       PH_ADDR,
    phase_count: 16'd0,
    address:     32'd0,
    length:      16'd0,
    invalid:     1'b0,
    finished:    1'b0,
    reply_total: 16'd0
  };

endpackage

`default_nettype wire

FILE: src/wbrp_parse.sv
`default_nettype none

// One parse step: next parser state and the tag for the byte
module wbrp_parse (
  input  wbrp_pkg::pstate_t st_i,
  input  logic [7:0]        byte_i,
  input  logic              masked_mode_i,
  input  logic [11:0]       request_length_i,
  output wbrp_pkg::pstate_t st_o,
  output wbrp_pkg::result_t res_o
);

  logic [11:0] rem;
  logic [11:0] rem_inc;
  logic [11:0] seen_inc;
  logic [16:0] cnt_inc;
  logic [15:0] len_next;
  logic [16:0] need;
  logic        end_reached;
  wbrp_pkg::kind_e kind;
  logic [7:0]  val;
  logic [15:0] off;

  assign seen_inc    = st_i.bytes_seen + 12'd1;
  assign rem         = (request_length_i > st_i.bytes_seen) ?
                       (request_length_i - st_i.bytes_seen) : 12'd0;
  assign rem_inc     = (request_length_i > seen_inc) ? (request_length_i - seen_inc) : 12'd0;
  assign cnt_inc     = {1'b0, st_i.phase_count} + 17'd1;
  assign len_next    = {st_i.length[7:0], byte_i};
  assign need        = masked_mode_i ? {len_next, 1'b0} : {1'b0, len_next};
  assign end_reached = (seen_inc >= request_length_i);

  always_comb begin
    st_o = st_i;
    kind = wbrp_pkg::KIND_IGNORED;
    val  = 8'd0;
    off  = 16'd0;
    if (!st_i.finished && !st_i.invalid) begin
      case (st_i.phase)
        wbrp_pkg::PH_ADDR: begin
          if (st_i.phase_count == 16'd0 && rem < wbrp_pkg::HDR_BYTES) begin
            st_o.invalid  = 1'b1;
            st_o.finished = 1'b1;
            kind          = wbrp_pkg::KIND_ERROR;
          end else begin
            if (st_i.phase_count == 16'd0) begin
              st_o.address = {24'd0, byte_i};
              st_o.length  = 16'd0;
            end else begin
              st_o.address = {st_i.address[23:0], byte_i};
            end
            st_o.bytes_seen = seen_inc;
            if (cnt_inc >= 17'(wbrp_pkg::ADDR_BYTES)) begin
              st_o.phase       = wbrp_pkg::PH_LEN;
              st_o.phase_count = 16'd0;
            end else begin
              st_o.phase_count = cnt_inc[15:0];
            end
            kind = wbrp_pkg::KIND_HEADER;
          end
        end
        wbrp_pkg::PH_LEN: begin
          st_o.length      = len_next;
          st_o.bytes_seen  = seen_inc;
          st_o.phase_count = cnt_inc[15:0];
          if (cnt_inc < 17'd2) begin
            kind = wbrp_pkg::KIND_HEADER;
          end else if (need > {5'd0, rem_inc}) begin
            st_o.invalid  = 1'b1;
            st_o.finished = 1'b1;
            kind          = wbrp_pkg::KIND_ERROR;
          end else begin
            st_o.reply_total = st_i.reply_total + 16'(wbrp_pkg::HDR_BYTES);
            st_o.phase_count = 16'd0;
            kind             = wbrp_pkg::KIND_START;
            // a zero-length block closes at its own start byte
            if (len_next == 16'd0) begin
              st_o.phase    = wbrp_pkg::PH_ADDR;
              st_o.finished = end_reached;
            end else begin
              st_o.phase = masked_mode_i ? wbrp_pkg::PH_DATA_M : wbrp_pkg::PH_DATA;
            end
          end
        end
        wbrp_pkg::PH_DATA, wbrp_pkg::PH_DATA_M, wbrp_pkg::PH_MASK: begin
          kind = (st_i.phase == wbrp_pkg::PH_MASK) ? wbrp_pkg::KIND_MASK
                                                   : wbrp_pkg::KIND_DATA;
          val              = byte_i;
          off              = st_i.phase_count;
          st_o.bytes_seen  = seen_inc;
          st_o.phase_count = cnt_inc[15:0];
          if (cnt_inc >= {1'b0, st_i.length}) begin
            st_o.phase_count = 16'd0;
            if (st_i.phase == wbrp_pkg::PH_DATA_M) begin
              st_o.phase = wbrp_pkg::PH_MASK;
            end else begin
              st_o.phase    = wbrp_pkg::PH_ADDR;
              st_o.finished = end_reached;
            end
          end
        end
        default: begin
          st_o.phase       = wbrp_pkg::PH_ADDR;
          st_o.phase_count = 16'd0;
        end
      endcase
    end
  end

  always_comb begin
    res_o.kind            = kind;
    res_o.block_address   = st_o.address;
    res_o.block_length    = st_o.length;
    res_o.byte_value      = val;
    res_o.byte_offset     = off;
    res_o.request_done    = st_o.finished | st_o.invalid;
    res_o.request_invalid = st_o.invalid;
    res_o.reply_size      = st_o.reply_total;
  end

endmodule

`default_nettype wire

FILE: src/write_block_request_parser_core.sv
`default_nettype none

// Write-block request parser: takes one request byte per transfer and returns one tagged
// result per byte (header, block start, data, mask, error or ignored) along with the
// current block address and length, the offset of data and mask bytes, the reply size and
// the done/invalid flags. Throughput is one byte per clock unless m_axis_tready holds the
// result back; a byte's result is presented from the result register: the byte waits in the
// input register while the single parse step runs on the parser state, and moves into the
// result register once it is free. Writing request_length restarts parsing; masked_mode
// is sampled at each block start. Write configuration only while no byte is in flight.
module write_block_request_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side: tdata = request_byte[7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [wbrp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata = block_address[31:0], block_length[47:32], byte_value[55:48],
  //         byte_offset[71:56], request_invalid[72], reply_size[88:73], zero[95:89]
  output logic [wbrp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser = byte_kind[2:0]
  output logic [wbrp_pkg::OUT_USER_W-1:0] m_axis_tuser,
  // tlast = request_done
  output logic             m_axis_tlast,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [wbrp_pkg::REQ_LEN_W-1:0] cfg_data_i
);

  logic        masked_q;
  logic [11:0] req_len_q;
  logic        cfg_clear;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  logic        out_free;
  logic        fire;

  wbrp_pkg::pstate_t st_q;
  wbrp_pkg::pstate_t st_d;
  wbrp_pkg::result_t res_d;
  wbrp_pkg::result_t res_q;

  assign cfg_clear     = cfg_we_i && (cfg_idx_i == wbrp_pkg::CFG_REQUEST_LENGTH);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masked_q  <= 1'b0;
      req_len_q <= 12'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wbrp_pkg::CFG_MASKED_MODE) begin
        masked_q <= cfg_data_i[0];
      end else begin
        req_len_q <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wbrp_parse u_parse (
    .st_i             (st_q),
    .byte_i           (in_byte_q),
    .masked_mode_i    (masked_q),
    .request_length_i (req_len_q),
    .st_o             (st_d),
    .res_o            (res_d)
  );

  // parser state: advance on every parsed byte, restart on a new request length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wbrp_pkg::PSTATE_CLEAR;
    end else if (cfg_clear) begin
      st_q <= wbrp_pkg::PSTATE_CLEAR;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.request_done;
  assign m_axis_tdata  = {7'd0, res_q.reply_size, res_q.request_invalid, res_q.byte_offset,
                          res_q.byte_value, res_q.block_length, res_q.block_address};

  // an error always stops parsing with the request marked done
  a_invalid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.request_invalid |-> res_q.request_done)
    else $error("invalid result without done");

  a_error_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == wbrp_pkg::KIND_ERROR |-> res_q.request_invalid)
    else $error("error byte without invalid flag");

  // once invalid, only a restart clears it
  a_invalid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.invalid && !cfg_clear |=> st_q.invalid)
    else $error("invalid flag dropped without restart");

  a_offset_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.kind == wbrp_pkg::KIND_DATA || res_q.kind == wbrp_pkg::KIND_MASK)
    |-> res_q.byte_offset < res_q.block_length)
    else $error("payload offset beyond block length");

endmodule

`default_nettype wire
